FILE: sv/touch_stroke_gesture_tracker_assert.svh
// Assertion macros for the touch stroke gesture tracker checkers.
`ifndef TOUCH_STROKE_GESTURE_TRACKER_ASSERT_SVH
`define TOUCH_STROKE_GESTURE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define TSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define TSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tsg_pkg.sv
// Shared types and constants of the touch stroke gesture tracker.
package tsg_pkg;

  localparam int          MaxStrokesDef  = 16;
  localparam int          ListBits       = 32;
  localparam int          CountBits      = 5;
  localparam logic [7:0]  MarginRstVal   = 8'd32;

  localparam logic [2:0]  PhaseFirst     = 3'd2;
  localparam logic [2:0]  PhaseHeld      = 3'd3;
  localparam logic [2:0]  PhaseRelease   = 3'd4;

  typedef enum logic [2:0] {
    DIR_IDLE  = 3'd0,
    DIR_START = 3'd1,
    DIR_UP    = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_DOWN  = 3'd4,
    DIR_RIGHT = 3'd5
  } dir_e;

  typedef enum logic [1:0] {
    STATUS_BUSY    = 2'd0,
    STATUS_STROKES = 2'd1,
    STATUS_NONE    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]           anchor_x;
    logic [7:0]           anchor_y;
    dir_e                 dir;
    logic [ListBits-1:0]  strokes;
    logic [CountBits-1:0] count;
  } state_t;

endpackage

FILE: sv/tsg_step.sv
// Next-state and status logic for one touch sample.
module tsg_step #(
  parameter int MAX_STROKES = tsg_pkg::MaxStrokesDef
) (
  input  tsg_pkg::state_t  state_i,
  input  logic             touch_pressed_i,
  input  logic [2:0]       touch_phase_i,
  input  logic [7:0]       pos_x_i,
  input  logic [7:0]       pos_y_i,
  input  logic [7:0]       move_margin_i,
  output tsg_pkg::state_t  state_o,
  output tsg_pkg::status_e status_o
);

  // Capacity is bounded by the 32-bit list.
  localparam int Cap = (MAX_STROKES < 16) ? MAX_STROKES : 16;

  always_comb begin
    logic          active;
    logic [7:0]    ax;
    logic [7:0]    ay;
    logic          go_down;
    logic          go_right;
    logic          go_left;
    logic          go_up;
    tsg_pkg::dir_e new_dir;
    logic [1:0]    code;

    state_o  = state_i;
    status_o = tsg_pkg::STATUS_BUSY;
    active   = 1'b1;
    ax       = state_i.anchor_x;
    ay       = state_i.anchor_y;
    new_dir  = state_i.dir;
    code     = 2'(3'(new_dir) - 3'(tsg_pkg::DIR_UP));
    go_down  = 1'b0;
    go_right = 1'b0;
    go_left  = 1'b0;
    go_up    = 1'b0;

    if (!touch_pressed_i && touch_phase_i != tsg_pkg::PhaseRelease) begin
      state_o.dir = tsg_pkg::DIR_IDLE;
    end else if (state_i.dir == tsg_pkg::DIR_IDLE && touch_phase_i == tsg_pkg::PhaseFirst) begin
      state_o.dir      = tsg_pkg::DIR_START;
      state_o.anchor_x = pos_x_i;
      state_o.anchor_y = pos_y_i;
      state_o.strokes  = '0;
      state_o.count    = '0;
    end else if (touch_phase_i == tsg_pkg::PhaseFirst || touch_phase_i == tsg_pkg::PhaseHeld) begin
      // Let the anchor follow the farthest extent in the current direction.
      case (state_i.dir)
        tsg_pkg::DIR_START: ;
        tsg_pkg::DIR_UP:    if (pos_y_i < ay) ay = pos_y_i;
        tsg_pkg::DIR_LEFT:  if (pos_x_i < ax) ax = pos_x_i;
        tsg_pkg::DIR_DOWN:  if (pos_y_i > ay) ay = pos_y_i;
        tsg_pkg::DIR_RIGHT: if (pos_x_i > ax) ax = pos_x_i;
        default:            active = 1'b0;
      endcase

      go_down  = {1'b0, pos_y_i} > ({1'b0, ay} + {1'b0, move_margin_i});
      go_right = {1'b0, pos_x_i} > ({1'b0, ax} + {1'b0, move_margin_i});
      go_left  = ({1'b0, pos_x_i} + {1'b0, move_margin_i}) < {1'b0, ax};
      go_up    = ({1'b0, pos_y_i} + {1'b0, move_margin_i}) < {1'b0, ay};

      // Priority: down, right, left, up.
      if (go_down) begin
        new_dir = tsg_pkg::DIR_DOWN;
      end else if (go_right) begin
        new_dir = tsg_pkg::DIR_RIGHT;
      end else if (go_left) begin
        new_dir = tsg_pkg::DIR_LEFT;
      end else if (go_up) begin
        new_dir = tsg_pkg::DIR_UP;
      end
      code = 2'(3'(new_dir) - 3'(tsg_pkg::DIR_UP));

      if (active) begin
        state_o.anchor_x = ax;
        state_o.anchor_y = ay;
        state_o.dir      = new_dir;
        if (new_dir != state_i.dir && state_i.count < tsg_pkg::CountBits'(Cap)) begin
          state_o.anchor_x = pos_x_i;
          state_o.anchor_y = pos_y_i;
          state_o.strokes  = state_i.strokes
                           | (tsg_pkg::ListBits'(code) << {state_i.count[3:0], 1'b0});
          state_o.count    = tsg_pkg::CountBits'(state_i.count + 5'd1);
        end
      end
    end else if (touch_phase_i == tsg_pkg::PhaseRelease) begin
      status_o = (state_i.count != '0) ? tsg_pkg::STATUS_STROKES : tsg_pkg::STATUS_NONE;
    end
  end

endmodule

FILE: sv/touch_stroke_gesture_tracker.sv
// Top level of the touch stroke gesture tracker.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------
//  s_t*     | in  | s_tvalid/s_tready  | s_tdata[23:0]  one touch sample
//  m_t*     | out | m_tvalid/m_tready  | m_tdata[47:0]  one result per sample
//  cfg_*    | in  | cfg_valid_i/ready  | cfg_data_i[7:0] move margin
//
// One sample per cycle while s_tready is high: the step logic reads the state
// registers and the sample, and the state and result registers load on the
// same edge, so the only loop is state -> step -> state.
// Each result appears in the cycle after its transfer; a stalled result holds in
// the output register and s_tready drops only while that register is full
// and not being taken. Reset (rst_ni low, asynchronous) sets the anchor to
// the origin, the direction to idle, clears the list and loads margin 32.
module touch_stroke_gesture_tracker #(
  parameter int MAX_STROKES = tsg_pkg::MaxStrokesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input samples
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] touch_pressed, [3:1] touch_phase, [11:4] pos_x, [19:12] pos_y, rest zero
  input  logic [23:0] s_tdata,
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] status, [33:2] stroke_list, [38:34] stroke_count,
  // [41:39] current_direction, rest zero
  output logic [47:0] m_tdata,
  // Margin register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  tsg_pkg::state_t  state_q, state_d;
  tsg_pkg::status_e status_d;
  logic [7:0]       margin_q;
  logic             out_valid_q;
  logic [41:0]      out_data_q;
  logic             in_xfer;

  // Accept a new sample whenever the result register is empty or draining.
  assign s_tready    = !out_valid_q || m_tready;
  assign in_xfer     = s_tvalid && s_tready;
  assign cfg_ready_o = 1'b1;

  tsg_step #(
    .MAX_STROKES(MAX_STROKES)
  ) u_step (
    .state_i        (state_q),
    .touch_pressed_i(s_tdata[0]),
    .touch_phase_i  (s_tdata[3:1]),
    .pos_x_i        (s_tdata[11:4]),
    .pos_y_i        (s_tdata[19:12]),
    .move_margin_i  (margin_q),
    .state_o        (state_d),
    .status_o       (status_d)
  );

  // Control and tracking state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.anchor_x <= '0;
      state_q.anchor_y <= '0;
      state_q.dir      <= tsg_pkg::DIR_IDLE;
      state_q.strokes  <= '0;
      state_q.count    <= '0;
      margin_q         <= tsg_pkg::MarginRstVal;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        margin_q <= cfg_data_i;
      end
      if (in_xfer) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every sample transfer, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {state_d.dir, state_d.count, state_d.strokes, status_d};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {6'b0, out_data_q};

endmodule

FILE: sv/tsg_checker.sv
// Port-level checker for the touch stroke gesture tracker, with its bind.
`include "touch_stroke_gesture_tracker_assert.svh"

module tsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  `TSG_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result changed while stalled")
  `TSG_ASSERT_NOW(a_full_blocks, m_tvalid && !m_tready, !s_tready,
    "sample taken while result stalled")
  `TSG_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[38:34] <= 5'd16,
    "stroke count above capacity")
  `TSG_ASSERT_NOW(a_status_count, m_tvalid && m_tdata[1:0] != tsg_pkg::STATUS_BUSY,
    (m_tdata[1:0] == tsg_pkg::STATUS_STROKES) == (m_tdata[38:34] != 5'd0),
    "release status disagrees with count")

endmodule

bind touch_stroke_gesture_tracker tsg_checker u_tsg_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
